/* src/cdu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdu_pkg - shared types and constants of the coordinate distance unit
// fixed point formats, pipeline depths, angle constants and rounding helpers
// ----------------------------------------------------------------------------
package cdu_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int CORDIC_STEPS  = 24;

   localparam int FIELD_W   = 32;
   localparam int OP_W      = 2;
   localparam int DIST_W    = 33;
   localparam int Q30_SHIFT = 30;
   localparam int ANG_SHIFT = Q30_SHIFT - FRACTION_BITS;

   // scaled angle width and number of range reduction steps
   localparam int ZW        = FIELD_W + ANG_SHIFT;
   localparam int RED_STEPS = 29 - FRACTION_BITS;

   // reduced angle and cordic datapath, trig results, cartesian coordinates
   localparam int AW   = 35;
   localparam int TW   = 33;
   localparam int RW   = 34;
   localparam int PW   = RW + TW;
   localparam int DW   = RW + 1;
   localparam int SQ_W = 2 * DW;
   localparam int SUMW = SQ_W + 2;
   localparam int RB   = DW + 1;
   localparam int SQW  = SUMW + 1;

   localparam int ANGLES  = 4;
   localparam int LANE_B1 = 0;
   localparam int LANE_C1 = 1;
   localparam int LANE_B2 = 2;
   localparam int LANE_C2 = 3;

   localparam int FRONT_LAT = RED_STEPS + CORDIC_STEPS + 5;
   localparam int BACK_LAT  = RB + 6;

   localparam int LQ_DEPTH = 4;
   localparam int LQ_AW    = $clog2(LQ_DEPTH);
   localparam int LQ_CW    = $clog2(LQ_DEPTH + 1);
   localparam int OQ_DEPTH = 2;
   localparam int OQ_AW    = $clog2(OQ_DEPTH);
   localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

   // angles in q30
   localparam logic [ZW-1:0]        TWO_PI_W     = ZW'(64'd6746518852);
   localparam logic signed [AW-1:0] ANG_TWO_PI   = AW'(64'sd6746518852);
   localparam logic signed [AW-1:0] ANG_PI       = AW'(64'sd3373259426);
   localparam logic signed [AW-1:0] ANG_HALF_PI  = AW'(64'sd1686629713);
   localparam logic signed [AW-1:0] CORDIC_START = AW'(64'sd652032874);

   typedef enum logic [OP_W-1:0] {
      MODE_CART    = 2'd0,
      MODE_POLAR   = 2'd1,
      MODE_SPHERE  = 2'd2,
      MODE_INVALID = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type                   mode;
      logic signed [FIELD_W-1:0]  first_a;
      logic signed [FIELD_W-1:0]  first_b;
      logic signed [FIELD_W-1:0]  first_c;
      logic signed [FIELD_W-1:0]  second_a;
      logic signed [FIELD_W-1:0]  second_b;
      logic signed [FIELD_W-1:0]  second_c;
   } item_type;

   typedef struct packed {
      item_type                     item;
      logic [ANGLES-1:0][TW-1:0]    sine;
      logic [ANGLES-1:0][TW-1:0]    cosine;
   } link_type;

   // floor(atan(2^-k) * 2^30)
   function automatic logic signed [AW-1:0] atan_q30(input int k);
      logic signed [AW-1:0] t;
      case (k)
         0:  t = AW'(843314856);
         1:  t = AW'(497837829);
         2:  t = AW'(263043836);
         3:  t = AW'(133525158);
         4:  t = AW'(67021686);
         5:  t = AW'(33543515);
         6:  t = AW'(16775850);
         7:  t = AW'(8388437);
         8:  t = AW'(4194282);
         9:  t = AW'(2097149);
         10: t = AW'(1048575);
         11: t = AW'(524287);
         12: t = AW'(262143);
         13: t = AW'(131071);
         14: t = AW'(65535);
         15: t = AW'(32767);
         16: t = AW'(16383);
         17: t = AW'(8191);
         18: t = AW'(4095);
         19: t = AW'(2047);
         20: t = AW'(1023);
         21: t = AW'(511);
         22: t = AW'(255);
         23: t = AW'(127);
         24: t = AW'(63);
         25: t = AW'(31);
         26: t = AW'(15);
         27: t = AW'(7);
         28: t = AW'(3);
         29: t = AW'(1);
         default: t = '0;
      endcase
      return t;
   endfunction

   // round a product with a q30 factor back to the coordinate format
   function automatic logic signed [RW-1:0] round_q30(input logic signed [PW-1:0] p);
      logic signed [PW:0] t;
      t = (PW + 1)'(p) + ((PW + 1)'(1) << (Q30_SHIFT - 1));
      return RW'(t >>> Q30_SHIFT);
   endfunction

endpackage
`default_nettype wire

/* src/cdu_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdu_front - intake, angle reduction and cordic sine/cosine
// stalls as a whole when its last stage cannot hand off to the link queue
// ----------------------------------------------------------------------------
module cdu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  cdu_pkg::item_type  req_item,
   output logic               link_push,
   output cdu_pkg::link_type  link_data,
   input  logic               link_full
);

   logic en;

   logic               pv_ff [cdu_pkg::FRONT_LAT];
   logic               pv_in [cdu_pkg::FRONT_LAT];
   cdu_pkg::item_type  pi_ff [cdu_pkg::FRONT_LAT];
   cdu_pkg::item_type  pi_in [cdu_pkg::FRONT_LAT];

   logic [cdu_pkg::ZW-1:0] rm_ff [cdu_pkg::RED_STEPS+1][cdu_pkg::ANGLES];
   logic [cdu_pkg::ZW-1:0] rm_in [cdu_pkg::RED_STEPS+1][cdu_pkg::ANGLES];
   logic                   rn_ff [cdu_pkg::RED_STEPS+1][cdu_pkg::ANGLES];
   logic                   rn_in [cdu_pkg::RED_STEPS+1][cdu_pkg::ANGLES];

   logic signed [cdu_pkg::AW-1:0] zr_ff [cdu_pkg::ANGLES];
   logic signed [cdu_pkg::AW-1:0] zr_in [cdu_pkg::ANGLES];
   logic signed [cdu_pkg::AW-1:0] zf_ff [cdu_pkg::ANGLES];
   logic signed [cdu_pkg::AW-1:0] zf_in [cdu_pkg::ANGLES];

   logic signed [cdu_pkg::AW-1:0] cx_ff [cdu_pkg::CORDIC_STEPS+1][cdu_pkg::ANGLES];
   logic signed [cdu_pkg::AW-1:0] cx_in [cdu_pkg::CORDIC_STEPS+1][cdu_pkg::ANGLES];
   logic signed [cdu_pkg::AW-1:0] cy_ff [cdu_pkg::CORDIC_STEPS+1][cdu_pkg::ANGLES];
   logic signed [cdu_pkg::AW-1:0] cy_in [cdu_pkg::CORDIC_STEPS+1][cdu_pkg::ANGLES];
   logic signed [cdu_pkg::AW-1:0] cz_ff [cdu_pkg::CORDIC_STEPS+1][cdu_pkg::ANGLES];
   logic signed [cdu_pkg::AW-1:0] cz_in [cdu_pkg::CORDIC_STEPS+1][cdu_pkg::ANGLES];
   logic                          cf_ff [cdu_pkg::CORDIC_STEPS+1][cdu_pkg::ANGLES];
   logic                          cf_in [cdu_pkg::CORDIC_STEPS+1][cdu_pkg::ANGLES];

   logic [cdu_pkg::ANGLES-1:0][cdu_pkg::TW-1:0] sin_ff, sin_in, cos_ff, cos_in;

   assign en       = ~(pv_ff[cdu_pkg::FRONT_LAT-1] & link_full);
   assign req_full = ~en;

   // item and valid shift line
   always_comb begin
      pv_in[0] = req_push;
      pi_in[0] = req_item;
      for (int i = 1; i < cdu_pkg::FRONT_LAT; i++) begin
         pv_in[i] = pv_ff[i-1];
         pi_in[i] = pi_ff[i-1];
      end
   end

   // scale to q30, split sign and magnitude, then subtract multiples of 2 pi
   always_comb begin
      logic signed [cdu_pkg::FIELD_W-1:0] ang [cdu_pkg::ANGLES];
      logic signed [cdu_pkg::ZW-1:0]      zs;
      logic [cdu_pkg::ZW-1:0]             step_c;
      ang[cdu_pkg::LANE_B1] = req_item.first_b;
      ang[cdu_pkg::LANE_C1] = req_item.first_c;
      ang[cdu_pkg::LANE_B2] = req_item.second_b;
      ang[cdu_pkg::LANE_C2] = req_item.second_c;
      for (int l = 0; l < cdu_pkg::ANGLES; l++) begin
         zs          = cdu_pkg::ZW'(ang[l]) <<< cdu_pkg::ANG_SHIFT;
         rn_in[0][l] = ang[l][cdu_pkg::FIELD_W-1];
         rm_in[0][l] = rn_in[0][l] ? $unsigned(-zs) : $unsigned(zs);
      end
      for (int j = 1; j <= cdu_pkg::RED_STEPS; j++) begin
         step_c = cdu_pkg::TWO_PI_W << (cdu_pkg::RED_STEPS - j);
         for (int l = 0; l < cdu_pkg::ANGLES; l++) begin
            rn_in[j][l] = rn_ff[j-1][l];
            rm_in[j][l] = (rm_ff[j-1][l] >= step_c) ? rm_ff[j-1][l] - step_c
                                                    : rm_ff[j-1][l];
         end
      end
   end

   // sign back on, fold into [-pi, pi]
   always_comb begin
      logic signed [cdu_pkg::AW-1:0] m;
      for (int l = 0; l < cdu_pkg::ANGLES; l++) begin
         m        = $signed(cdu_pkg::AW'(rm_ff[cdu_pkg::RED_STEPS][l]));
         zr_in[l] = rn_ff[cdu_pkg::RED_STEPS][l] ? -m : m;
         if (zr_ff[l] > cdu_pkg::ANG_PI) begin
            zf_in[l] = zr_ff[l] - cdu_pkg::ANG_TWO_PI;
         end else if (zr_ff[l] < -cdu_pkg::ANG_PI) begin
            zf_in[l] = zr_ff[l] + cdu_pkg::ANG_TWO_PI;
         end else begin
            zf_in[l] = zr_ff[l];
         end
      end
   end

   // fold into [-pi/2, pi/2], then one rotation per stage
   always_comb begin
      logic signed [cdu_pkg::AW-1:0] xs, ys;
      for (int l = 0; l < cdu_pkg::ANGLES; l++) begin
         cx_in[0][l] = cdu_pkg::CORDIC_START;
         cy_in[0][l] = '0;
         if (zf_ff[l] > cdu_pkg::ANG_HALF_PI) begin
            cz_in[0][l] = zf_ff[l] - cdu_pkg::ANG_PI;
            cf_in[0][l] = 1'b1;
         end else if (zf_ff[l] < -cdu_pkg::ANG_HALF_PI) begin
            cz_in[0][l] = zf_ff[l] + cdu_pkg::ANG_PI;
            cf_in[0][l] = 1'b1;
         end else begin
            cz_in[0][l] = zf_ff[l];
            cf_in[0][l] = 1'b0;
         end
      end
      for (int s = 0; s < cdu_pkg::CORDIC_STEPS; s++) begin
         for (int l = 0; l < cdu_pkg::ANGLES; l++) begin
            xs            = cx_ff[s][l] >>> s;
            ys            = cy_ff[s][l] >>> s;
            cf_in[s+1][l] = cf_ff[s][l];
            if (cz_ff[s][l] >= 0) begin
               cx_in[s+1][l] = cx_ff[s][l] - ys;
               cy_in[s+1][l] = cy_ff[s][l] + xs;
               cz_in[s+1][l] = cz_ff[s][l] - cdu_pkg::atan_q30(s);
            end else begin
               cx_in[s+1][l] = cx_ff[s][l] + ys;
               cy_in[s+1][l] = cy_ff[s][l] - xs;
               cz_in[s+1][l] = cz_ff[s][l] + cdu_pkg::atan_q30(s);
            end
         end
      end
      for (int l = 0; l < cdu_pkg::ANGLES; l++) begin
         sin_in[l] = cdu_pkg::TW'(cf_ff[cdu_pkg::CORDIC_STEPS][l]
                                  ? -cy_ff[cdu_pkg::CORDIC_STEPS][l]
                                  : cy_ff[cdu_pkg::CORDIC_STEPS][l]);
         cos_in[l] = cdu_pkg::TW'(cf_ff[cdu_pkg::CORDIC_STEPS][l]
                                  ? -cx_ff[cdu_pkg::CORDIC_STEPS][l]
                                  : cx_ff[cdu_pkg::CORDIC_STEPS][l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cdu_pkg::FRONT_LAT; i++) begin
            pv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         pv_ff <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pi_ff  <= pi_in;
         rm_ff  <= rm_in;
         rn_ff  <= rn_in;
         zr_ff  <= zr_in;
         zf_ff  <= zf_in;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         cz_ff  <= cz_in;
         cf_ff  <= cf_in;
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign link_push = pv_ff[cdu_pkg::FRONT_LAT-1] & ~link_full;

   always_comb begin
      link_data.item   = pi_ff[cdu_pkg::FRONT_LAT-1];
      link_data.sine   = sin_ff;
      link_data.cosine = cos_ff;
   end

endmodule
`default_nettype wire

/* src/cdu_link_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdu_link_queue - short queue between the trig front and the distance back
// lets either side stall without stopping the other
// ----------------------------------------------------------------------------
module cdu_link_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cdu_pkg::link_type  push_data,
   output logic               full,
   input  logic               pop,
   output cdu_pkg::link_type  pop_data,
   output logic               empty
);

   cdu_pkg::link_type           mem_ff [cdu_pkg::LQ_DEPTH];
   logic [cdu_pkg::LQ_AW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [cdu_pkg::LQ_CW-1:0]   cnt_ff, cnt_in;
   logic                        do_push, do_pop;

   assign full     = (cnt_ff == cdu_pkg::LQ_CW'(cdu_pkg::LQ_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wp_in = (wp_ff == cdu_pkg::LQ_AW'(cdu_pkg::LQ_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (do_pop) begin
         rp_in = (rp_ff == cdu_pkg::LQ_AW'(cdu_pkg::LQ_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* src/cdu_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdu_back - cartesian conversion, squared distance and pipelined square root
// ends in a small result queue; stalls only when that queue is full
// ----------------------------------------------------------------------------
module cdu_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        lq_empty,
   input  cdu_pkg::link_type           lq_data,
   output logic                        lq_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [cdu_pkg::DIST_W-1:0]  rsp_distance,
   output logic                        rsp_mode_error
);

   localparam int L = cdu_pkg::BACK_LAT - 1;

   logic en, oq_full, oq_push, oq_pop;

   logic bv_ff [cdu_pkg::BACK_LAT];
   logic bv_in [cdu_pkg::BACK_LAT];
   logic be_ff [cdu_pkg::BACK_LAT];
   logic be_in [cdu_pkg::BACK_LAT];

   cdu_pkg::link_type b0_ff, b1_lk_ff;

   logic signed [cdu_pkg::RW-1:0] ac_ff [2];
   logic signed [cdu_pkg::RW-1:0] ac_in [2];
   logic signed [cdu_pkg::RW-1:0] as_ff [2];
   logic signed [cdu_pkg::RW-1:0] as_in [2];
   logic signed [cdu_pkg::RW-1:0] pt_ff [2][3];
   logic signed [cdu_pkg::RW-1:0] pt_in [2][3];
   logic signed [cdu_pkg::DW-1:0] d_ff  [3];
   logic signed [cdu_pkg::DW-1:0] d_in  [3];
   logic [cdu_pkg::SQ_W-1:0]      sq_ff [3];
   logic [cdu_pkg::SQ_W-1:0]      sq_in [3];

   logic [cdu_pkg::SUMW-1:0] srem_ff  [cdu_pkg::RB+1];
   logic [cdu_pkg::SUMW-1:0] srem_in  [cdu_pkg::RB+1];
   logic [cdu_pkg::RB-1:0]   sroot_ff [cdu_pkg::RB+1];
   logic [cdu_pkg::RB-1:0]   sroot_in [cdu_pkg::RB+1];

   logic [cdu_pkg::DIST_W-1:0] oq_dist_ff [cdu_pkg::OQ_DEPTH];
   logic                       oq_err_ff  [cdu_pkg::OQ_DEPTH];
   logic [cdu_pkg::OQ_AW-1:0]  oq_wp_ff, oq_wp_in, oq_rp_ff, oq_rp_in;
   logic [cdu_pkg::OQ_CW-1:0]  oq_cnt_ff, oq_cnt_in;
   logic [cdu_pkg::DIST_W-1:0] dist_out;

   assign oq_full = (oq_cnt_ff == cdu_pkg::OQ_CW'(cdu_pkg::OQ_DEPTH));
   assign en      = ~(bv_ff[L] & oq_full);
   assign lq_pop  = en & ~lq_empty;
   assign oq_push = bv_ff[L] & ~oq_full;

   always_comb begin
      bv_in[0] = ~lq_empty;
      be_in[0] = (lq_data.item.mode == cdu_pkg::MODE_INVALID);
      for (int i = 1; i < cdu_pkg::BACK_LAT; i++) begin
         bv_in[i] = bv_ff[i-1];
         be_in[i] = be_ff[i-1];
      end
   end

   // radius times the sine and cosine of theta
   always_comb begin
      logic signed [cdu_pkg::FIELD_W-1:0] a;
      logic signed [cdu_pkg::PW-1:0]      pc, ps;
      int                                 lb;
      for (int q = 0; q < 2; q++) begin
         a  = (q == 0) ? b0_ff.item.first_a : b0_ff.item.second_a;
         lb = (q == 0) ? cdu_pkg::LANE_B1 : cdu_pkg::LANE_B2;
         pc = cdu_pkg::PW'(a) * cdu_pkg::PW'($signed(b0_ff.cosine[lb]));
         ps = cdu_pkg::PW'(a) * cdu_pkg::PW'($signed(b0_ff.sine[lb]));
         ac_in[q] = cdu_pkg::round_q30(pc);
         as_in[q] = cdu_pkg::round_q30(ps);
      end
   end

   // second rotation for spherical points and selection per mode
   always_comb begin
      logic signed [cdu_pkg::PW-1:0] pc, ps;
      cdu_pkg::item_type             it;
      int                            lc;
      it = b1_lk_ff.item;
      for (int q = 0; q < 2; q++) begin
         lc = (q == 0) ? cdu_pkg::LANE_C1 : cdu_pkg::LANE_C2;
         pc = cdu_pkg::PW'(as_ff[q]) * cdu_pkg::PW'($signed(b1_lk_ff.cosine[lc]));
         ps = cdu_pkg::PW'(as_ff[q]) * cdu_pkg::PW'($signed(b1_lk_ff.sine[lc]));
         case (it.mode)
            cdu_pkg::MODE_CART: begin
               pt_in[q][0] = cdu_pkg::RW'((q == 0) ? it.first_a : it.second_a);
               pt_in[q][1] = cdu_pkg::RW'((q == 0) ? it.first_b : it.second_b);
               pt_in[q][2] = cdu_pkg::RW'((q == 0) ? it.first_c : it.second_c);
            end
            cdu_pkg::MODE_POLAR: begin
               pt_in[q][0] = ac_ff[q];
               pt_in[q][1] = as_ff[q];
               pt_in[q][2] = '0;
            end
            cdu_pkg::MODE_SPHERE: begin
               pt_in[q][0] = cdu_pkg::round_q30(pc);
               pt_in[q][1] = cdu_pkg::round_q30(ps);
               pt_in[q][2] = ac_ff[q];
            end
            default: begin
               pt_in[q][0] = '0;
               pt_in[q][1] = '0;
               pt_in[q][2] = '0;
            end
         endcase
      end
   end

   // differences and squares
   always_comb begin
      logic signed [cdu_pkg::SQ_W-1:0] sqs;
      for (int k = 0; k < 3; k++) begin
         d_in[k]  = cdu_pkg::DW'(pt_ff[0][k]) - cdu_pkg::DW'(pt_ff[1][k]);
         sqs      = cdu_pkg::SQ_W'(d_ff[k]) * cdu_pkg::SQ_W'(d_ff[k]);
         sq_in[k] = $unsigned(sqs);
      end
   end

   // sum, then square root, one result bit per stage, remainder kept as value - root^2
   always_comb begin
      logic [cdu_pkg::SQW-1:0] trial;
      int                      b;
      srem_in[0]  = cdu_pkg::SUMW'(sq_ff[0]) + cdu_pkg::SUMW'(sq_ff[1])
                  + cdu_pkg::SUMW'(sq_ff[2]);
      sroot_in[0] = '0;
      for (int s = 0; s < cdu_pkg::RB; s++) begin
         b     = cdu_pkg::RB - 1 - s;
         trial = (cdu_pkg::SQW'(sroot_ff[s]) << (b + 1)) | (cdu_pkg::SQW'(1) << (2 * b));
         if (cdu_pkg::SQW'(srem_ff[s]) >= trial) begin
            srem_in[s+1]  = cdu_pkg::SUMW'(cdu_pkg::SQW'(srem_ff[s]) - trial);
            sroot_in[s+1] = sroot_ff[s] | (cdu_pkg::RB'(1) << b);
         end else begin
            srem_in[s+1]  = srem_ff[s];
            sroot_in[s+1] = sroot_ff[s];
         end
      end
   end

   // saturate, and force zero for an invalid mode
   always_comb begin
      if (be_ff[L]) begin
         dist_out = '0;
      end else if (|sroot_ff[cdu_pkg::RB][cdu_pkg::RB-1:cdu_pkg::DIST_W]) begin
         dist_out = '1;
      end else begin
         dist_out = sroot_ff[cdu_pkg::RB][cdu_pkg::DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cdu_pkg::BACK_LAT; i++) begin
            bv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         bv_ff <= bv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         be_ff    <= be_in;
         b0_ff    <= lq_data;
         b1_lk_ff <= b0_ff;
         ac_ff    <= ac_in;
         as_ff    <= as_in;
         pt_ff    <= pt_in;
         d_ff     <= d_in;
         sq_ff    <= sq_in;
         srem_ff  <= srem_in;
         sroot_ff <= sroot_in;
      end
   end

   // result queue
   assign rsp_empty      = (oq_cnt_ff == '0);
   assign oq_pop         = rsp_pop & ~rsp_empty;
   assign rsp_distance   = oq_dist_ff[oq_rp_ff];
   assign rsp_mode_error = oq_err_ff[oq_rp_ff];

   always_comb begin
      oq_wp_in  = oq_wp_ff;
      oq_rp_in  = oq_rp_ff;
      oq_cnt_in = oq_cnt_ff;
      if (oq_push) begin
         oq_wp_in = (oq_wp_ff == cdu_pkg::OQ_AW'(cdu_pkg::OQ_DEPTH - 1)) ? '0
                                                                        : oq_wp_ff + 1'b1;
      end
      if (oq_pop) begin
         oq_rp_in = (oq_rp_ff == cdu_pkg::OQ_AW'(cdu_pkg::OQ_DEPTH - 1)) ? '0
                                                                        : oq_rp_ff + 1'b1;
      end
      if (oq_push & ~oq_pop) begin
         oq_cnt_in = oq_cnt_ff + 1'b1;
      end else if (oq_pop & ~oq_push) begin
         oq_cnt_in = oq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wp_ff  <= '0;
         oq_rp_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         oq_wp_ff  <= oq_wp_in;
         oq_rp_ff  <= oq_rp_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_dist_ff[oq_wp_ff] <= dist_out;
         oq_err_ff[oq_wp_ff]  <= be_ff[L];
      end
   end

endmodule
`default_nettype wire

/* src/coordinate_distance_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coordinate_distance_unit - distance between two points in one coordinate system
// cartesian, polar or spherical pairs; cordic trig, exact squares, pipelined root
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  req_      in         req_push / req_full  req_operation, req_first_*, req_second_*
//  rsp_      out        rsp_pop / rsp_empty  rsp_distance, rsp_mode_error
//
//  one transfer per cycle sustained on each side while no queue is full; an item
//  passes through the trig front (range reduction, folds, cordic rotations), the
//  link queue, where it is registered, and the back (conversion, squares, root bits)
//  the trig front and the distance back each stall only on their own full queue
//  synchronous reset clears valids and queue pointers; no other state is kept
//
module coordinate_distance_unit (
   input  logic                                clock,
   input  logic                                reset,

   // request side
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [cdu_pkg::OP_W-1:0]            req_operation,
   input  logic signed [cdu_pkg::FIELD_W-1:0]  req_first_a,
   input  logic signed [cdu_pkg::FIELD_W-1:0]  req_first_b,
   input  logic signed [cdu_pkg::FIELD_W-1:0]  req_first_c,
   input  logic signed [cdu_pkg::FIELD_W-1:0]  req_second_a,
   input  logic signed [cdu_pkg::FIELD_W-1:0]  req_second_b,
   input  logic signed [cdu_pkg::FIELD_W-1:0]  req_second_c,

   // response side
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [cdu_pkg::DIST_W-1:0]          rsp_distance,
   output logic                                rsp_mode_error
);

   cdu_pkg::item_type req_item;
   cdu_pkg::link_type link_in, link_out;
   logic              link_push, link_full, link_pop, link_empty;

   // gather the request transfer into one item
   always_comb begin
      req_item.mode     = cdu_pkg::mode_type'(req_operation);
      req_item.first_a  = req_first_a;
      req_item.first_b  = req_first_b;
      req_item.first_c  = req_first_c;
      req_item.second_a = req_second_a;
      req_item.second_b = req_second_b;
      req_item.second_c = req_second_c;
   end

   // angle reduction and sine/cosine for all four angles of the pair
   cdu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .link_push (link_push),
      .link_data (link_in),
      .link_full (link_full)
   );

   // decouples the two halves
   cdu_link_queue u_link (
      .clock     (clock),
      .reset     (reset),
      .push      (link_push),
      .push_data (link_in),
      .full      (link_full),
      .pop       (link_pop),
      .pop_data  (link_out),
      .empty     (link_empty)
   );

   // conversion, squares, root and the result queue
   cdu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .lq_empty       (link_empty),
      .lq_data        (link_out),
      .lq_pop         (link_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_distance   (rsp_distance),
      .rsp_mode_error (rsp_mode_error)
   );

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the coordinate distance unit
// drives point pairs in every coordinate system through the request queue,
// predicts untyped distances with a bit-exact cordic and integer root model and
// compares every response transfer in order; both sides idle at random
// ----------------------------------------------------------------------------
module tb_top;

   localparam int  HALF_PERIOD  = 1;
   localparam int  RESET_CYCLES = 11;
   localparam int  RANDOM_ITEMS = 1520;
   localparam int  DRAIN_CYCLES = 120;   // well past the pipeline depth
   localparam int  MAX_WAIT     = 5;

   // angle constants in q30
   localparam longint TURN      = 64'sd6746518852;
   localparam longint HALF_TURN = 64'sd3373259426;
   localparam longint QUARTER   = 64'sd1686629713;
   localparam longint GAIN_INV  = 64'sd652032874;
   localparam logic [cdu_pkg::DIST_W-1:0] DIST_TOP = '1;

   // floor(atan(2^-k) * 2^30)
   localparam longint ARCTAN [0:31] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
      127, 63, 31, 15, 7, 3, 1, 0, 0};

   typedef struct {
      logic [cdu_pkg::DIST_W-1:0] distance;
      logic                       mode_error;
   } outcome_type;

   typedef struct {
      cdu_pkg::item_type item;
      bit                typed;      // expected outcome typed into the table
      outcome_type       want;
   } stim_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_push = 1'b0;
   logic                               req_full;
   logic [cdu_pkg::OP_W-1:0]           req_operation = '0;
   logic signed [cdu_pkg::FIELD_W-1:0] req_first_a = '0;
   logic signed [cdu_pkg::FIELD_W-1:0] req_first_b = '0;
   logic signed [cdu_pkg::FIELD_W-1:0] req_first_c = '0;
   logic signed [cdu_pkg::FIELD_W-1:0] req_second_a = '0;
   logic signed [cdu_pkg::FIELD_W-1:0] req_second_b = '0;
   logic signed [cdu_pkg::FIELD_W-1:0] req_second_c = '0;
   logic                               rsp_empty;
   logic                               rsp_pop = 1'b0;
   logic [cdu_pkg::DIST_W-1:0]         rsp_distance;
   logic                               rsp_mode_error;

   outcome_type  pending_distances[$];
   stim_row_type directed_rows[$];
   int           mismatch_count = 0;
   bit           send_calm = 1'b0;   // stretches with no sender idling
   bit           take_calm = 1'b0;   // stretches with no receiver stalls

   always #HALF_PERIOD clock = ~clock;

   coordinate_distance_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_operation  (req_operation),
      .req_first_a    (req_first_a),
      .req_first_b    (req_first_b),
      .req_first_c    (req_first_c),
      .req_second_a   (req_second_a),
      .req_second_b   (req_second_b),
      .req_second_c   (req_second_c),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_distance   (rsp_distance),
      .rsp_mode_error (rsp_mode_error)
   );

   // ------------------------------------------------------------------------
   // distance predictor
   // ------------------------------------------------------------------------

   // rotation-mode cordic after folding the angle into [-pi/2, pi/2]
   function automatic void cordic_sin_cos(input longint theta, output longint s,
                                          output longint c);
      longint z, x, y, xs, ys;
      bit     mirror;
      z      = theta * (longint'(1) << (cdu_pkg::Q30_SHIFT - cdu_pkg::FRACTION_BITS));
      x      = GAIN_INV;
      y      = 0;
      mirror = 1'b0;
      z      = z % TURN;   // truncating remainder, sign of the dividend
      if (z > HALF_TURN) z -= TURN;
      else if (z < -HALF_TURN) z += TURN;
      // outer half circle: rotate by pi and negate both results
      if (z > QUARTER) begin
         z -= HALF_TURN;
         mirror = 1'b1;
      end else if (z < -QUARTER) begin
         z += HALF_TURN;
         mirror = 1'b1;
      end
      for (int k = 0; k < cdu_pkg::CORDIC_STEPS; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= ARCTAN[k];
         end else begin
            x += ys;
            y -= xs;
            z += ARCTAN[k];
         end
      end
      s = mirror ? -y : y;
      c = mirror ? -x : x;
   endfunction

   function automatic longint rescale_q30(input longint p);
      return (p + (longint'(1) << (cdu_pkg::Q30_SHIFT - 1))) >>> cdu_pkg::Q30_SHIFT;
   endfunction

   function automatic void to_cartesian(input cdu_pkg::mode_type mode, input longint a,
                                        input longint b, input longint c,
                                        output longint px, output longint py,
                                        output longint pz);
      longint sb, cb, sc, cc, rs;
      if (mode == cdu_pkg::MODE_CART) begin
         px = a;
         py = b;
         pz = c;
      end else begin
         cordic_sin_cos(b, sb, cb);
         if (mode == cdu_pkg::MODE_POLAR) begin
            px = rescale_q30(a * cb);
            py = rescale_q30(a * sb);
            pz = 0;
         end else begin
            cordic_sin_cos(c, sc, cc);
            rs = rescale_q30(a * sb);
            px = rescale_q30(rs * cc);
            py = rescale_q30(rs * sc);
            pz = rescale_q30(a * cb);
         end
      end
   endfunction

   function automatic logic [127:0] square_of(input longint d);
      logic [127:0] m;
      m = (d < 0) ? 128'(-d) : 128'(d);
      return m * m;
   endfunction

   function automatic outcome_type predict_distance(input cdu_pkg::item_type it);
      outcome_type  o;
      longint       x1, y1, z1, x2, y2, z2;
      logic [127:0] sum, trial;
      logic [63:0]  root;
      o.distance   = '0;
      o.mode_error = 1'b0;
      if (it.mode == cdu_pkg::MODE_INVALID) begin
         o.mode_error = 1'b1;
         return o;
      end
      to_cartesian(it.mode, it.first_a, it.first_b, it.first_c, x1, y1, z1);
      to_cartesian(it.mode, it.second_a, it.second_b, it.second_c, x2, y2, z2);
      sum  = square_of(x1 - x2) + square_of(y1 - y2) + square_of(z1 - z2);
      // bitwise floor root
      root = '0;
      for (int b = 40; b >= 0; b--) begin
         trial = 128'(root | (64'd1 << b));
         if (trial * trial <= sum) root = trial[63:0];
      end
      o.distance = (root > 64'(DIST_TOP)) ? DIST_TOP : root[cdu_pkg::DIST_W-1:0];
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   function automatic int draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic logic signed [cdu_pkg::FIELD_W-1:0] random_field(input bit angle);
      logic signed [cdu_pkg::FIELD_W-1:0] v;
      case ($urandom_range(0, 5))
         0:       v = $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0:       v = 32'sh8000_0000;
               1:       v = 32'sh7fff_ffff;
               2:       v = -32'sd1;
               default: v = '0;
            endcase
         end
         // a few radians either way for angles, moderate values otherwise
         default: v = angle ? $signed($urandom_range(0, 917504)) - 32'sd458752
                            : $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      endcase
      return v;
   endfunction

   function automatic cdu_pkg::item_type random_pair();
      cdu_pkg::item_type it;
      it.mode     = cdu_pkg::mode_type'($urandom_range(0, 7) == 0 ? cdu_pkg::MODE_INVALID
                                                                  : $urandom_range(0, 2));
      it.first_a  = random_field(1'b0);
      it.second_a = random_field(1'b0);
      it.first_b  = random_field(it.mode != cdu_pkg::MODE_CART);
      it.second_b = random_field(it.mode != cdu_pkg::MODE_CART);
      it.first_c  = random_field(it.mode == cdu_pkg::MODE_SPHERE);
      it.second_c = random_field(it.mode == cdu_pkg::MODE_SPHERE);
      return it;
   endfunction

   function automatic void add_row(input cdu_pkg::mode_type m, input int fa, input int fb,
                                   input int fc, input int sa, input int sb,
                                   input int sc, input bit typed,
                                   input logic [cdu_pkg::DIST_W-1:0] want_dist,
                                   input bit err);
      stim_row_type r;
      r.item                = '{m, fa, fb, fc, sa, sb, sc};
      r.typed               = typed;
      r.want.distance       = want_dist;
      r.want.mode_error     = err;
      directed_rows.push_back(r);
   endfunction

   // one request transfer; push stays high across back-to-back items
   task automatic send_pair(input cdu_pkg::item_type it, input bit typed,
                            input outcome_type want);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_operation <= it.mode;
      req_first_a   <= it.first_a;
      req_first_b   <= it.first_b;
      req_first_c   <= it.first_c;
      req_second_a  <= it.second_a;
      req_second_b  <= it.second_b;
      req_second_c  <= it.second_c;
      do @(posedge clock); while (req_full);
      pending_distances.push_back(typed ? want : predict_distance(it));
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // response side: check each transfer against the oldest expectation
   // ------------------------------------------------------------------------
   initial begin
      int          stall;
      outcome_type want;
      stall = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            if (pending_distances.size() == 0) begin
               report_mismatch("unexpected response", rsp_distance, 0);
            end else begin
               want = pending_distances.pop_front();
               if (rsp_distance !== want.distance)
                  report_mismatch("distance", rsp_distance, want.distance);
               if (rsp_mode_error !== want.mode_error)
                  report_mismatch("mode_error", rsp_mode_error, want.mode_error);
            end
            if ($urandom_range(0, 99) == 0) take_calm = !take_calm;
            stall = draw_wait(take_calm);
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // request side and end of run
   // ------------------------------------------------------------------------
   initial begin
      outcome_type none;
      none = '{'0, 1'b0};

      // directed table: invalid mode, cartesian extremes, trig special cases
      add_row(cdu_pkg::MODE_INVALID, 32'h7fffffff, 1, 2, 3, 4, 5, 1, '0, 1'b1);
      add_row(cdu_pkg::MODE_INVALID, 0, 0, 0, 0, 0, 0, 1, '0, 1'b1);
      add_row(cdu_pkg::MODE_CART, 0, 0, 0, 0, 0, 0, 1, '0, 1'b0);
      add_row(cdu_pkg::MODE_CART, 32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 1,
              33'h0ffffffff, 1'b0);
      add_row(cdu_pkg::MODE_CART, 0, 32'h7fffffff, 0, 0, 32'h80000000, 0, 1,
              33'h0ffffffff, 1'b0);
      add_row(cdu_pkg::MODE_CART, 0, 0, 32'h80000000, 0, 0, 32'h7fffffff, 1,
              33'h0ffffffff, 1'b0);
      add_row(cdu_pkg::MODE_CART, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, '0, 1'b0);
      add_row(cdu_pkg::MODE_CART, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 1,
              33'h50000, 1'b0);
      add_row(cdu_pkg::MODE_CART, -1, -1, -1, 32'hffffffff, 0, 1, 0, '0, 1'b0);
      add_row(cdu_pkg::MODE_POLAR, 32'h10000, 0, 0, 32'h10000, 32'h3243f, 0, 0, '0, 1'b0);
      add_row(cdu_pkg::MODE_POLAR, 32'h7fffffff, 32'h7fffffff, 0,
              32'h80000000, 32'h80000000, 0, 0, '0, 1'b0);
      // negative radius mirrors through the origin
      add_row(cdu_pkg::MODE_POLAR, 32'hfff00000, 32'h1921f, 5, 32'h00100000, 32'h1921f, 7,
              0, '0, 1'b0);
      add_row(cdu_pkg::MODE_POLAR, 32'h10000, 32'h80000000, 0, 32'h10000, 32'h7fffffff, 0,
              0, '0, 1'b0);
      add_row(cdu_pkg::MODE_SPHERE, 32'h20000, 32'h1921f, 32'h1921f, 32'h20000, 0, 0,
              0, '0, 1'b0);
      add_row(cdu_pkg::MODE_SPHERE, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h7fffffff, 0, '0, 1'b0);
      add_row(cdu_pkg::MODE_SPHERE, 32'h80000000, 32'h3243f, 32'hfffcdbc1,
              32'h7fffffff, 32'hfffcdbc1, 32'h3243f, 0, '0, 1'b0);
      // angles at and just past the half turn and quarter turn folds
      add_row(cdu_pkg::MODE_SPHERE, 32'h00050000, 32'h00032440, 32'hfffe6de1,
              32'h00050000, 32'h0001921f, 32'hfffcdbbf, 0, '0, 1'b0);
      add_row(cdu_pkg::MODE_SPHERE, 32'hffff0000, 0, 0, 32'hffff0000, 32'h12345678,
              32'hedcba987, 0, '0, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_pair(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      // hold off until the pipeline has fully drained once
      req_push <= 1'b0;
      do @(posedge clock); while (pending_distances.size() != 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
         send_pair(random_pair(), 1'b0, none);
      end
      req_push <= 1'b0;

      do @(posedge clock); while (pending_distances.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_distances.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
